[hdl/sdbc_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sdbc_pkg
// Shared types and codes of the sector deblocking buffer controller.
// ----------------------------------------------------------------------------
package sdbc_pkg;

  localparam int OP_W      = 3;
  localparam int DRIVE_W   = 2;
  localparam int TRACK_W   = 10;
  localparam int SECTOR_W  = 8;
  localparam int CMD_W     = 3;
  localparam int BLOCK_W   = 16;
  localparam int SLOT_W    = 2;
  localparam int MOTBITS_W = 4;
  localparam int TLEN_W    = 8;
  localparam int HOLD_W    = 24;
  localparam int NUM_TLEN  = 4;

  // Widest logical sector: 255 * 1023 + 255 fits in 18 bits.
  localparam int LOGICAL_W = 18;

  // Configuration port
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 24;

  localparam logic [CFG_IDX_W-1:0] CFG_TLEN0 = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TLEN1 = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_TLEN2 = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_TLEN3 = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_HOLD  = 3'd4;

  localparam logic [TLEN_W-1:0] TLEN_RESET = 8'd26;
  localparam logic [HOLD_W-1:0] HOLD_RESET = 24'd3000;

  // Operation codes
  localparam logic [OP_W-1:0] OP_READ      = 3'd0;
  localparam logic [OP_W-1:0] OP_WRITE     = 3'd1;
  localparam logic [OP_W-1:0] OP_DIR_WRITE = 3'd2;
  localparam logic [OP_W-1:0] OP_TICK      = 3'd3;
  localparam logic [OP_W-1:0] OP_RESET     = 3'd4;

  // Command codes
  localparam logic [CMD_W-1:0] CMD_STATUS = 3'd0;
  localparam logic [CMD_W-1:0] CMD_FLUSH  = 3'd1;
  localparam logic [CMD_W-1:0] CMD_FILL   = 3'd2;
  localparam logic [CMD_W-1:0] CMD_OUT    = 3'd3;
  localparam logic [CMD_W-1:0] CMD_IN     = 3'd4;

  typedef struct packed {
    logic [OP_W-1:0]     operation;
    logic [DRIVE_W-1:0]  drive;
    logic [TRACK_W-1:0]  track;
    logic [SECTOR_W-1:0] sector;
  } in_item_t;

  typedef struct packed {
    logic [CMD_W-1:0]     command;
    logic [DRIVE_W-1:0]   cmd_drive;
    logic [BLOCK_W-1:0]   cmd_block;
    logic [SLOT_W-1:0]    slot;
    logic [MOTBITS_W-1:0] motors_running;
    logic                 last;
  } out_item_t;

endpackage

[hdl/sector_deblocking_buffer_control.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sector_deblocking_buffer_control
// Controller of a one-entry write-back deblocking buffer: maps a drive,
// track and sector to a block and slot, tracks the buffer tags and the drive
// motors, and issues flush / fill / copy commands one beat at a time.
// ----------------------------------------------------------------------------
//
//  Channel  Ports                              Direction  Beat
//  -------  ---------------------------------  ---------  ----------------------
//  in       in_valid, in_stall, in_data        to block   one request
//  out      out_valid, out_stall, out_data     from block one command, 1..4/req
//  cfg      cfg_we, cfg_index, cfg_wdata       to block   one register write
//
//  A request causes one to four commands, the worst being a dirty miss
//  on a directory write (flush, fill, copy in, flush). The command
//  sequencer issues them one beat at a time; the two address stages ahead
//  of it take a new beat each cycle while the stages behind them accept,
//  and the first command of a request passes the address stages, the
//  sequencer register and the output register before it shows on out_valid.
//  Reset (rst_n low, synchronous) empties the pipeline, invalidates the
//  buffer, stops all motors and reloads the register defaults.
//  out_stall holds the output register; the sequencer and the address
//  stages back up behind it and in_stall rises only when all are full.
//
module sector_deblocking_buffer_control #(
  parameter int DRIVE_COUNT       = 4,
  parameter int SECTORS_PER_BLOCK = 4
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  sdbc_pkg::in_item_t                 in_data,
  output logic                               out_valid,
  input  logic                               out_stall,
  output sdbc_pkg::out_item_t                out_data,
  input  logic                               cfg_we,
  input  logic [sdbc_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [sdbc_pkg::CFG_DATA_W-1:0]    cfg_wdata
);
  import sdbc_pkg::*;

  // Only drives 0..3 are addressable, so at most four motors exist.
  localparam int MOTORS = (DRIVE_COUNT < 4) ? DRIVE_COUNT : 4;

  // Block number by reciprocal multiply: q = (L * RECIP) >> SHIFT is exact
  // for every L below 2**LOGICAL_W.
  localparam int SHIFT = LOGICAL_W + $clog2(SECTORS_PER_BLOCK);
  localparam logic [LOGICAL_W:0] RECIP =
    (LOGICAL_W + 1)'(((64'd1 << SHIFT) + 64'(SECTORS_PER_BLOCK) - 64'd1) /
                     64'(SECTORS_PER_BLOCK));
  localparam int PROD_W = 2 * LOGICAL_W + 1;

  typedef enum logic {
    PH_LOOKUP,
    PH_DIR_FLUSH
  } phase_t;

  // --------------------------------------------------------------------------
  // Configuration registers
  // --------------------------------------------------------------------------
  logic [TLEN_W-1:0] tlen_r [NUM_TLEN];
  logic [HOLD_W-1:0] hold_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_TLEN; i++) begin
        tlen_r[i] <= TLEN_RESET;
      end
      hold_r <= HOLD_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_TLEN0: tlen_r[0] <= cfg_wdata[TLEN_W-1:0];
        CFG_TLEN1: tlen_r[1] <= cfg_wdata[TLEN_W-1:0];
        CFG_TLEN2: tlen_r[2] <= cfg_wdata[TLEN_W-1:0];
        CFG_TLEN3: tlen_r[3] <= cfg_wdata[TLEN_W-1:0];
        CFG_HOLD:  hold_r    <= cfg_wdata[HOLD_W-1:0];
        default: ;
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Flow control: each stage loads when empty or when its beat moves on
  // --------------------------------------------------------------------------
  logic s1_vld_r, s2_vld_r, s3_vld_r, out_vld_r;
  logic s1_ready, s2_ready, s3_ready;
  logic emit_go, cmd_last;

  assign emit_go  = s3_vld_r && (!out_vld_r || !out_stall);
  assign s3_ready = !s3_vld_r || (emit_go && cmd_last);
  assign s2_ready = !s2_vld_r || s3_ready;
  assign s1_ready = !s1_vld_r || s2_ready;
  assign in_stall = !s1_ready;

  // --------------------------------------------------------------------------
  // Stage 1: logical sector = track_length[drive] * track + sector
  // --------------------------------------------------------------------------
  logic [OP_W-1:0]      s1_op_r;
  logic [DRIVE_W-1:0]   s1_drv_r;
  logic [LOGICAL_W-1:0] s1_lsec_r;
  logic [LOGICAL_W-1:0] lsec_nxt;

  assign lsec_nxt = LOGICAL_W'(tlen_r[in_data.drive]) * LOGICAL_W'(in_data.track) +
                    LOGICAL_W'(in_data.sector);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
    end else if (s1_ready) begin
      s1_vld_r <= in_valid;
    end
    if (s1_ready && in_valid) begin
      s1_op_r   <= in_data.operation;
      s1_drv_r  <= in_data.drive;
      s1_lsec_r <= lsec_nxt;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 2: block number = logical / SECTORS_PER_BLOCK
  // --------------------------------------------------------------------------
  logic [OP_W-1:0]      s2_op_r;
  logic [DRIVE_W-1:0]   s2_drv_r;
  logic [LOGICAL_W-1:0] s2_lsec_r;
  logic [LOGICAL_W-1:0] s2_quot_r;
  logic [PROD_W-1:0]    recip_prod;

  assign recip_prod = PROD_W'(s1_lsec_r) * PROD_W'(RECIP);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_vld_r <= 1'b0;
    end else if (s2_ready) begin
      s2_vld_r <= s1_vld_r;
    end
    if (s2_ready && s1_vld_r) begin
      s2_op_r   <= s1_op_r;
      s2_drv_r  <= s1_drv_r;
      s2_lsec_r <= s1_lsec_r;
      s2_quot_r <= LOGICAL_W'(recip_prod >> SHIFT);
    end
  end

  // --------------------------------------------------------------------------
  // Stage 3: command sequencer
  // --------------------------------------------------------------------------
  logic [OP_W-1:0]      s3_op_r;
  logic [DRIVE_W-1:0]   s3_drv_r;
  logic [LOGICAL_W-1:0] s3_lsec_r;
  logic [LOGICAL_W-1:0] s3_quot_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_vld_r <= 1'b0;
    end else if (s3_ready) begin
      s3_vld_r <= s2_vld_r;
    end
    if (s3_ready && s2_vld_r) begin
      s3_op_r   <= s2_op_r;
      s3_drv_r  <= s2_drv_r;
      s3_lsec_r <= s2_lsec_r;
      s3_quot_r <= s2_quot_r;
    end
  end

  // Slot is the remainder; the block number wraps at 16 bits.
  logic [LOGICAL_W-1:0] quot_back;
  logic [LOGICAL_W-1:0] rem;
  logic [BLOCK_W-1:0]   req_blk;
  logic [SLOT_W-1:0]    req_slot;

  assign quot_back = LOGICAL_W'(s3_quot_r * LOGICAL_W'(SECTORS_PER_BLOCK));
  assign rem       = s3_lsec_r - quot_back;
  assign req_blk   = s3_quot_r[BLOCK_W-1:0];
  assign req_slot  = rem[SLOT_W-1:0];

  // Buffer tags and motors
  phase_t             phase_r, phase_nxt;
  logic               buf_valid_r, buf_valid_nxt;
  logic               buf_dirty_r, buf_dirty_nxt;
  logic [DRIVE_W-1:0] buf_drv_r, buf_drv_nxt;
  logic [BLOCK_W-1:0] buf_blk_r, buf_blk_nxt;
  logic               run_r   [MOTORS];
  logic               run_nxt [MOTORS];
  logic [HOLD_W-1:0]  cd_r    [MOTORS];
  logic [HOLD_W-1:0]  cd_nxt  [MOTORS];

  logic               hit;
  logic               acc_en;
  logic [DRIVE_W-1:0] acc_drv;
  logic               do_tick, do_stop;
  out_item_t          cmd;

  assign hit = buf_valid_r && (buf_drv_r == s3_drv_r) && (buf_blk_r == req_blk);

  always_comb begin
    phase_nxt     = phase_r;
    buf_valid_nxt = buf_valid_r;
    buf_dirty_nxt = buf_dirty_r;
    buf_drv_nxt   = buf_drv_r;
    buf_blk_nxt   = buf_blk_r;
    acc_en        = 1'b0;
    acc_drv       = s3_drv_r;
    do_tick       = 1'b0;
    do_stop       = 1'b0;
    cmd           = '0;
    cmd.command   = CMD_STATUS;
    cmd.last      = 1'b1;

    if (s3_op_r inside {OP_READ, OP_WRITE, OP_DIR_WRITE}) begin
      cmd.cmd_drive = s3_drv_r;
      cmd.cmd_block = req_blk;
      if (phase_r == PH_DIR_FLUSH) begin
        // Directory write: force the freshly written block out
        cmd.command   = CMD_FLUSH;
        acc_en        = 1'b1;
        buf_dirty_nxt = 1'b0;
        phase_nxt     = PH_LOOKUP;
      end else if (!hit && buf_valid_r && buf_dirty_r) begin
        // Miss on a dirty buffer: write back the old block first
        cmd.command   = CMD_FLUSH;
        cmd.cmd_drive = buf_drv_r;
        cmd.cmd_block = buf_blk_r;
        cmd.last      = 1'b0;
        acc_en        = 1'b1;
        acc_drv       = buf_drv_r;
        buf_dirty_nxt = 1'b0;
      end else if (!hit) begin
        cmd.command   = CMD_FILL;
        cmd.last      = 1'b0;
        acc_en        = 1'b1;
        buf_valid_nxt = 1'b1;
        buf_dirty_nxt = 1'b0;
        buf_drv_nxt   = s3_drv_r;
        buf_blk_nxt   = req_blk;
      end else if (s3_op_r == OP_READ) begin
        cmd.command = CMD_OUT;
        cmd.slot    = req_slot;
      end else begin
        cmd.command   = CMD_IN;
        cmd.slot      = req_slot;
        buf_dirty_nxt = 1'b1;
        if (s3_op_r == OP_DIR_WRITE) begin
          cmd.last  = 1'b0;
          phase_nxt = PH_DIR_FLUSH;
        end
      end
    end else begin
      case (s3_op_r)
        OP_TICK: do_tick = 1'b1;
        OP_RESET: begin
          // Drop the buffer contents, stop every motor
          buf_valid_nxt = 1'b0;
          buf_dirty_nxt = 1'b0;
          do_stop       = 1'b1;
        end
        default: ;
      endcase
    end

    for (int i = 0; i < MOTORS; i++) begin
      run_nxt[i] = run_r[i];
      cd_nxt[i]  = cd_r[i];
      if (do_stop) begin
        run_nxt[i] = 1'b0;
        cd_nxt[i]  = '0;
      end else if (do_tick && run_r[i]) begin
        if (cd_r[i] <= HOLD_W'(1)) begin
          run_nxt[i] = 1'b0;
          cd_nxt[i]  = '0;
        end else begin
          cd_nxt[i] = cd_r[i] - HOLD_W'(1);
        end
      end else if (acc_en && (acc_drv == DRIVE_W'(i))) begin
        run_nxt[i] = 1'b1;
        cd_nxt[i]  = hold_r;
      end
    end

    // Report the motor state as it stands after this command
    cmd.motors_running = '0;
    for (int i = 0; i < MOTORS; i++) begin
      cmd.motors_running[i] = run_nxt[i];
    end
  end

  assign cmd_last = cmd.last;

  out_item_t out_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_LOOKUP;
      buf_valid_r <= 1'b0;
      buf_dirty_r <= 1'b0;
      buf_drv_r   <= '0;
      buf_blk_r   <= '0;
      for (int i = 0; i < MOTORS; i++) begin
        run_r[i] <= 1'b0;
        cd_r[i]  <= '0;
      end
      out_vld_r <= 1'b0;
    end else begin
      if (emit_go) begin
        phase_r     <= phase_nxt;
        buf_valid_r <= buf_valid_nxt;
        buf_dirty_r <= buf_dirty_nxt;
        buf_drv_r   <= buf_drv_nxt;
        buf_blk_r   <= buf_blk_nxt;
        for (int i = 0; i < MOTORS; i++) begin
          run_r[i] <= run_nxt[i];
          cd_r[i]  <= cd_nxt[i];
        end
        out_r     <= cmd;
        out_vld_r <= 1'b1;
      end else if (!out_stall) begin
        out_vld_r <= 1'b0;
      end
    end
  end

  assign out_valid = out_vld_r;
  assign out_data  = out_r;

`ifndef SYNTHESIS
  // A dirty buffer always holds a valid block
  a_dirty_valid: assert property (@(posedge clk) disable iff (!rst_n)
    buf_dirty_r |-> buf_valid_r)
    else $error("buffer dirty while not valid");

  // Motor 0, when stopped, has no countdown left
  a_motor_idle: assert property (@(posedge clk) disable iff (!rst_n)
    !run_r[0] |-> (cd_r[0] == '0))
    else $error("stopped motor with nonzero countdown");

  // Status beats end a request; fills never do
  a_status_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_data.command == CMD_STATUS)) |-> out_data.last)
    else $error("status beat without last");

  a_fill_not_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_data.command == CMD_FILL)) |-> !out_data.last)
    else $error("fill beat marked last");

  // An empty front address stage never pushes back on the input
  a_no_false_stall: assert property (@(posedge clk) disable iff (!rst_n)
    !s1_vld_r |-> !in_stall)
    else $error("input stalled with empty front stage");
`endif

endmodule

[dv/sector_deblocking_buffer_control_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sector_deblocking_buffer_control_tb
// Self-checking bench for the deblocking buffer controller. Sends read, write,
// directory-write, tick, reset and spare-opcode requests, keeps its own copy of
// the buffer tags and drive motors, and checks every command beat in order.
// ----------------------------------------------------------------------------
module sector_deblocking_buffer_control_tb;
  import sdbc_pkg::*;

  localparam int DRIVE_COUNT       = 4;
  localparam int SECTORS_PER_BLOCK = 4;
  localparam int MAX_SHOWN         = 10;
  localparam int WATCHDOG_LIMIT    = 2000;
  localparam int HOLD_OFF_CYCLES   = 160;
  localparam int SETTLE_CYCLES     = 8;
  localparam int PHASE_ITEMS       = 26;

  // Operation codes the block treats as no-ops
  localparam logic [OP_W-1:0] OP_SPARE5 = 3'd5;
  localparam logic [OP_W-1:0] OP_SPARE6 = 3'd6;
  localparam logic [OP_W-1:0] OP_SPARE7 = 3'd7;

  // --------------------------------------------------------------------------
  // Buffer and motor tracker: predicts the command beats of each request
  // --------------------------------------------------------------------------
  class sdbc_scoreboard;
    logic [TLEN_W-1:0]  track_len [NUM_TLEN];
    logic [HOLD_W-1:0]  hold_ticks;
    bit                 buf_valid;
    bit                 buf_dirty;
    logic [DRIVE_W-1:0] buf_drive;
    logic [BLOCK_W-1:0] buf_block;
    bit                 motor_on   [NUM_TLEN];
    logic [HOLD_W-1:0]  motor_left [NUM_TLEN];
    out_item_t          burst [$];
    out_item_t          expected_cmds [$];
    int                 mismatches;

    function new();
      for (int i = 0; i < NUM_TLEN; i++) begin
        track_len[i]  = TLEN_RESET;
        motor_on[i]   = 1'b0;
        motor_left[i] = '0;
      end
      hold_ticks = HOLD_RESET;
      buf_valid  = 1'b0;
      buf_dirty  = 1'b0;
      buf_drive  = '0;
      buf_block  = '0;
      mismatches = 0;
    endfunction

    function void write_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      if (idx == CFG_HOLD)
        hold_ticks = data[HOLD_W-1:0];
      else if (idx < NUM_TLEN)
        track_len[idx] = data[TLEN_W-1:0];
    endfunction

    function logic [MOTBITS_W-1:0] motor_mask();
      logic [MOTBITS_W-1:0] m;
      m = '0;
      for (int i = 0; i < DRIVE_COUNT; i++)
        m[i] = motor_on[i];
      return m;
    endfunction

    // Start the motor of a present drive and re-arm its countdown
    function void spin_up(logic [DRIVE_W-1:0] d);
      if (d < DRIVE_COUNT) begin
        motor_on[d]   = 1'b1;
        motor_left[d] = hold_ticks;
      end
    endfunction

    function void add_cmd(logic [CMD_W-1:0] cmd, logic [DRIVE_W-1:0] d,
                          logic [BLOCK_W-1:0] blk, logic [SLOT_W-1:0] slot);
      out_item_t c;
      c.command        = cmd;
      c.cmd_drive      = d;
      c.cmd_block      = blk;
      c.slot           = slot;
      c.motors_running = motor_mask();
      c.last           = 1'b0;
      burst.push_back(c);
    endfunction

    function void note_request(in_item_t req);
      int unsigned        lsec;
      logic [BLOCK_W-1:0] blk;
      logic [SLOT_W-1:0]  slot;
      bit                 hit;
      burst.delete();
      if (req.operation == OP_READ || req.operation == OP_WRITE ||
          req.operation == OP_DIR_WRITE) begin
        lsec = track_len[req.drive] * req.track + req.sector;
        blk  = BLOCK_W'(lsec / SECTORS_PER_BLOCK);
        slot = SLOT_W'(lsec % SECTORS_PER_BLOCK);
        hit  = buf_valid && buf_drive == req.drive && buf_block == blk;
        if (!hit) begin
          // Write back the old block first when it holds unflushed data
          if (buf_valid && buf_dirty) begin
            spin_up(buf_drive);
            buf_dirty = 1'b0;
            add_cmd(CMD_FLUSH, buf_drive, buf_block, '0);
          end
          buf_drive = req.drive;
          buf_block = blk;
          buf_valid = 1'b1;
          buf_dirty = 1'b0;
          spin_up(req.drive);
          add_cmd(CMD_FILL, req.drive, blk, '0);
        end
        if (req.operation == OP_READ) begin
          add_cmd(CMD_OUT, req.drive, blk, slot);
        end else begin
          buf_dirty = 1'b1;
          add_cmd(CMD_IN, req.drive, blk, slot);
          if (req.operation == OP_DIR_WRITE) begin
            spin_up(req.drive);
            buf_dirty = 1'b0;
            add_cmd(CMD_FLUSH, req.drive, blk, '0);
          end
        end
      end else begin
        if (req.operation == OP_TICK) begin
          for (int i = 0; i < DRIVE_COUNT; i++) begin
            if (motor_on[i]) begin
              if (motor_left[i] <= 1) begin
                motor_left[i] = '0;
                motor_on[i]   = 1'b0;
              end else begin
                motor_left[i] = motor_left[i] - 1'b1;
              end
            end
          end
        end else if (req.operation == OP_RESET) begin
          buf_valid = 1'b0;
          buf_dirty = 1'b0;
          for (int i = 0; i < NUM_TLEN; i++) begin
            motor_on[i]   = 1'b0;
            motor_left[i] = '0;
          end
        end
        add_cmd(CMD_STATUS, '0, '0, '0);
      end
      burst[burst.size()-1].last = 1'b1;
      foreach (burst[i])
        expected_cmds.push_back(burst[i]);
    endfunction

    function string fmt(out_item_t c);
      return $sformatf("cmd=%0d drv=%0d blk=%0d slot=%0d motors=%b last=%0d",
                       c.command, c.cmd_drive, c.cmd_block, c.slot,
                       c.motors_running, c.last);
    endfunction

    function void check_command(out_item_t got);
      out_item_t want;
      if (expected_cmds.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_SHOWN)
          $display("ERROR %0t: command beat with none pending: %s", $time, fmt(got));
        return;
      end
      want = expected_cmds.pop_front();
      if (got.command !== want.command || got.cmd_drive !== want.cmd_drive ||
          got.cmd_block !== want.cmd_block || got.slot !== want.slot ||
          got.motors_running !== want.motors_running || got.last !== want.last) begin
        mismatches++;
        if (mismatches <= MAX_SHOWN)
          $display("ERROR %0t: expected %s, got %s", $time, fmt(want), fmt(got));
      end
    endfunction

    function int pending();
      return expected_cmds.size();
    endfunction
  endclass

  // --------------------------------------------------------------------------
  // Signals and instance
  // --------------------------------------------------------------------------
  logic                  clk;
  logic                  rst_n;
  logic                  in_valid;
  logic                  in_stall;
  in_item_t              in_data;
  logic                  out_valid;
  logic                  out_stall;
  out_item_t             out_data;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  sdbc_scoreboard sb = new();

  // Idle rates in percent, changed per phase by the main sequence
  int in_idle_pct   = 0;
  int out_stall_pct = 0;
  // Set to ask the result sink for one long hold-off
  bit hold_off_req  = 1'b0;

  // Recent address, reused so that most random requests hit or neighbor it
  logic [DRIVE_W-1:0]  near_drive  = '0;
  logic [TRACK_W-1:0]  near_track  = '0;
  logic [SECTOR_W-1:0] near_sector = '0;

  sector_deblocking_buffer_control #(
    .DRIVE_COUNT       (DRIVE_COUNT),
    .SECTORS_PER_BLOCK (SECTORS_PER_BLOCK)
  ) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // --------------------------------------------------------------------------
  // Request side
  // --------------------------------------------------------------------------
  function automatic in_item_t make_req(logic [OP_W-1:0] op, int d, int trk, int sec);
    in_item_t r;
    r.operation = op;
    r.drive     = DRIVE_W'(d);
    r.track     = TRACK_W'(trk);
    r.sector    = SECTOR_W'(sec);
    return r;
  endfunction

  // Mostly well-formed traffic around a recent address, some far jumps,
  // ticks to run motors down, and the odd reset or spare opcode.
  function automatic in_item_t random_req();
    in_item_t r;
    int       pick;
    pick = $urandom_range(99);
    if (pick < 35)      r.operation = OP_READ;
    else if (pick < 60) r.operation = OP_WRITE;
    else if (pick < 68) r.operation = OP_DIR_WRITE;
    else if (pick < 88) r.operation = OP_TICK;
    else if (pick < 94) r.operation = OP_RESET;
    else                r.operation = OP_W'($urandom_range(OP_SPARE7, OP_SPARE5));
    pick = $urandom_range(99);
    if (pick < 55) begin
      // stay in or next to the current block
      r.drive  = near_drive;
      r.track  = near_track;
      r.sector = near_sector ^ SECTOR_W'($urandom_range(3));
    end else if (pick < 75) begin
      r.drive  = near_drive;
      r.track  = near_track + TRACK_W'($urandom_range(2));
      r.sector = SECTOR_W'($urandom_range(255));
    end else begin
      r.drive  = DRIVE_W'($urandom_range(3));
      r.track  = TRACK_W'($urandom_range(1023));
      r.sector = SECTOR_W'($urandom_range(255));
    end
    if (r.operation <= OP_DIR_WRITE) begin
      near_drive  = r.drive;
      near_track  = r.track;
      near_sector = r.sector;
    end
    return r;
  endfunction

  // Offer one beat, idling first at the phase's rate; hold it until taken.
  task automatic send_req(in_item_t req);
    while ($urandom_range(99) < in_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= req;
    @(posedge clk);
    while (in_stall)
      @(posedge clk);
    sb.note_request(req);
  endtask

  // Drain all pending commands, let the pipeline settle, then load registers.
  task automatic program_registers(int t0, int t1, int t2, int t3, int hold);
    int vals [5];
    logic [CFG_IDX_W-1:0] idx [5];
    vals = '{t0, t1, t2, t3, hold};
    idx  = '{CFG_TLEN0, CFG_TLEN1, CFG_TLEN2, CFG_TLEN3, CFG_HOLD};
    in_valid <= 1'b0;
    while (sb.pending() != 0)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    for (int i = 0; i < 5; i++) begin
      cfg_we    <= 1'b1;
      cfg_index <= idx[i];
      cfg_wdata <= CFG_DATA_W'(vals[i]);
      @(posedge clk);
      sb.write_register(idx[i], CFG_DATA_W'(vals[i]));
    end
    cfg_we <= 1'b0;
  endtask

  task automatic random_phase(int idle_in, int stall_out, bit squeeze);
    in_idle_pct   = idle_in;
    out_stall_pct = stall_out;
    if (squeeze)
      hold_off_req = 1'b1;
    for (int n = 0; n < PHASE_ITEMS; n++)
      send_req(random_req());
  endtask

  // --------------------------------------------------------------------------
  // Result sink: check each accepted beat, stall at the phase's rate
  // --------------------------------------------------------------------------
  initial begin : result_sink
    int hold_left;
    hold_left = 0;
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_valid && !out_stall)
        sb.check_command(out_data);
      if (hold_off_req) begin
        hold_left    = HOLD_OFF_CYCLES;
        hold_off_req = 1'b0;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= ($urandom_range(99) < out_stall_pct);
      end
    end
  end

  // --------------------------------------------------------------------------
  // Watchdog: end the run if no beat moves on either channel for too long
  // --------------------------------------------------------------------------
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall))
        quiet = 0;
      else
        quiet++;
    end
    $display("ERROR %0t: no beat moved for %0d cycles", $time, WATCHDOG_LIMIT);
    $display("Simulation FAILED");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin : main_seq
    rst_n     <= 1'b0;
    in_valid  <= 1'b0;
    in_data   <= '0;
    cfg_we    <= 1'b0;
    cfg_index <= CFG_TLEN0;
    cfg_wdata <= '0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed, reset register values (26 sectors per track, long hold)
    send_req(make_req(OP_READ, 0, 0, 0));          // cold miss: fill, copy out
    send_req(make_req(OP_READ, 0, 0, 3));          // hit, top slot
    send_req(make_req(OP_WRITE, 0, 0, 1));         // hit, buffer turns dirty
    send_req(make_req(OP_READ, 1, 1023, 255));     // dirty miss: flush, fill, out
    send_req(make_req(OP_DIR_WRITE, 1, 1023, 254)); // hit: copy in, forced flush
    send_req(make_req(OP_WRITE, 2, 5, 7));         // clean miss on another drive
    send_req(make_req(OP_DIR_WRITE, 3, 512, 128)); // worst case: four beats
    send_req(make_req(OP_TICK, 0, 0, 0));
    send_req(make_req(OP_WRITE, 3, 512, 129));     // dirty the buffer again
    send_req(make_req(OP_RESET, 3, 1023, 255));    // drop dirty data, stop motors
    send_req(make_req(OP_READ, 2, 0, 0));          // no flush after the reset
    send_req(make_req(OP_SPARE5, 1, 1, 1));
    send_req(make_req(OP_SPARE6, 2, 682, 170));
    send_req(make_req(OP_SPARE7, 3, 341, 85));

    // Zero track length and zero hold
    program_registers(0, 0, 0, 0, 0);
    send_req(make_req(OP_READ, 0, 1023, 255));     // logical sector is the sector
    send_req(make_req(OP_TICK, 0, 0, 0));          // motor armed at zero stops
    send_req(make_req(OP_WRITE, 0, 7, 253));

    // Longest tracks: highest block number; shortest non-zero hold
    program_registers(255, 255, 255, 255, 1);
    send_req(make_req(OP_READ, 3, 1023, 255));
    send_req(make_req(OP_WRITE, 3, 1023, 254));
    send_req(make_req(OP_TICK, 0, 0, 0));
    send_req(make_req(OP_DIR_WRITE, 0, 0, 0));     // dirty miss across drives

    // Random phases, each under its own register set and idle pattern
    program_registers($urandom_range(255, 1), $urandom_range(255, 1),
                      $urandom_range(255, 1), $urandom_range(255, 1),
                      $urandom_range(8, 1));
    random_phase(0, 0, 1'b0);
    program_registers(255, 255, 255, 255, 24'hFFFFFF);
    random_phase(85, 0, 1'b0);
    program_registers(1, 1, 1, 1, 1);
    random_phase(0, 85, 1'b0);
    program_registers($urandom_range(255), $urandom_range(255),
                      $urandom_range(255), $urandom_range(255),
                      $urandom_range(3));
    random_phase(31, 31, 1'b0);
    // Long receiver hold-off with the sender still pushing: back up to in_stall
    program_registers(TLEN_RESET, 26, 13, 1, 2);
    random_phase(0, 0, 1'b1);

    in_valid <= 1'b0;
    while (sb.pending() != 0)
      @(posedge clk);
    repeat (20) @(posedge clk);

    if (sb.pending() != 0)
      $display("ERROR: %0d command beats never arrived", sb.pending());
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("%0d command mismatches", sb.mismatches);
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

[sector_deblocking_buffer_control.f]
hdl/sdbc_pkg.sv
hdl/sector_deblocking_buffer_control.sv
dv/sector_deblocking_buffer_control_tb.sv
